// ===== rtl/core/led_matrix_bitplane_scan_defines.svh =====
// Assertion macros for the LED matrix bit-plane scan block.
`ifndef LED_MATRIX_BITPLANE_SCAN_DEFINES_SVH
`define LED_MATRIX_BITPLANE_SCAN_DEFINES_SVH
`ifndef SYNTH
`define LMBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define LMBS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition");
`else
`define LMBS_ASSERT(lbl, clk, rstn, prop)
`define LMBS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/core/lmbs_pkg.sv =====
// Shared types and constants for the LED matrix bit-plane scan block.
package lmbs_pkg;
  typedef enum logic [1:0] {
    OP_RGB888 = 2'd0,
    OP_RGB565 = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SCAN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_CLEAR = 2'd1,
    K_SCAN  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] off_r;
    logic [7:0] off_g;
    logic [7:0] off_b;
    logic [2:0] bitpos;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } entry_t;

  localparam int unsigned PLANE_BYTES = 192;
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME = 8'd1;
endpackage

// ===== rtl/core/lmbs_front.sv =====
// Front end: decodes operations, expands color and maps pixels to byte offsets.
module lmbs_front
  import lmbs_pkg::*;
(
  input  logic        accept_i,
  input  logic        scan_mode_i,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  pos_x_i,
  input  logic [4:0]  pos_y_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [15:0] packed_color_i,
  output logic        push_o,
  output entry_t      entry_o
);
  logic [4:0]  mx;
  logic [1:0]  col;
  logic [3:0]  y;
  logic [7:0]  base;
  logic [7:0]  off;
  logic [14:0] rx, gx, bx;
  logic        in_range;
  op_e         op;

  assign op = op_e'(operation_i);
  assign mx = 5'd31 - pos_x_i[4:0];
  assign col = mx[4:3];
  assign y = pos_y_i[3:0];
  assign in_range = !pos_x_i[5] && !pos_y_i[4];

  assign rx = 15'(packed_color_i[15:11]) * 15'd527 + 15'd23;
  assign gx = 15'(packed_color_i[10:5]) * 15'd259 + 15'd33;
  assign bx = 15'(packed_color_i[4:0]) * 15'd527 + 15'd23;

  always_comb begin
    if (!scan_mode_i) begin
      base = {1'b0, y[1:0], 5'b0} + {2'b0, y[1:0], 4'b0};
      off = base + {5'b0, col, 1'b0};
      if (y >= 4'd12) begin
        off = off + 8'd9;
      end else if (y >= 4'd8) begin
        off = off + 8'd8;
      end else if (y >= 4'd4) begin
        off = off + 8'd1;
      end
      entry_o.off_r = off;
      entry_o.off_g = off + 8'd16;
      entry_o.off_b = off + 8'd32;
    end else begin
      base = {1'b0, y[2:0], 4'b0} + {2'b0, y[2:0], 3'b0};
      off = base + {6'b0, col} + (y[3] ? 8'd4 : 8'd0);
      entry_o.off_r = off;
      entry_o.off_g = off + 8'd8;
      entry_o.off_b = off + 8'd16;
    end
    entry_o.bitpos = mx[2:0];
    entry_o.red = red_i;
    entry_o.green = green_i;
    entry_o.blue = blue_i;
    entry_o.kind = K_WRITE;
    push_o = 1'b0;
    case (op)
      OP_RGB888: begin
        push_o = accept_i && in_range;
      end
      OP_RGB565: begin
        entry_o.red = rx[13:6];
        entry_o.green = gx[13:6];
        entry_o.blue = bx[13:6];
        push_o = accept_i && in_range;
      end
      OP_CLEAR: begin
        entry_o.kind = K_CLEAR;
        push_o = accept_i;
      end
      OP_SCAN: begin
        entry_o.kind = K_SCAN;
        push_o = accept_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end
endmodule

// ===== rtl/core/lmbs_fifo.sv =====
// Two-entry command queue between front end and back end.
module lmbs_fifo
  import lmbs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o,
  output logic   full_o
);
  `include "led_matrix_bitplane_scan_defines.svh"

  entry_t     slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign head_o = slot_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `LMBS_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o)
  `LMBS_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o)
  `LMBS_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'd2)
  `LMBS_ASSERT(a_push_fills, clk_i, rst_ni, push_i && !pop_i |=> !empty_o)
endmodule

// ===== rtl/core/lmbs_back.sv =====
// Back end: frame store, plane updates, clearing sweep and row scan output.
module lmbs_back
  import lmbs_pkg::*;
#(
  parameter int unsigned NUM_PLANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        scan_mode_i,
  input  logic [15:0] on_time_i,
  input  entry_t      head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  row_select_o,
  output logic [2:0]  plane_index_o,
  output logic        last_in_row_o,
  output logic [15:0] enable_time_o
);
  localparam int unsigned STEP = 256 / NUM_PLANES;
  localparam int unsigned HALF = STEP / 2;
  localparam int unsigned DEPTH = NUM_PLANES * PLANE_BYTES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [PW-1:0] P_LAST = PW'(NUM_PLANES - 1);
  localparam logic [PW-1:0] G0 = PW'(3 % NUM_PLANES);
  localparam logic [PW-1:0] B0 = PW'(6 % NUM_PLANES);

  typedef enum logic [2:0] {
    S_IDLE, S_CLR, S_WR_RD, S_WR_WB, S_SC_RD, S_SC_WT
  } state_e;

  state_e         state_q;
  logic           init_q;
  logic [AW-1:0]  clr_q;
  logic [PW-1:0]  c_q, pg_q, pb_q, plane_q;
  logic [1:0]     ch_q;
  logic [5:0]     j_q;
  logic [2:0]     rc_q;
  logic [7:0]     mem [DEPTH];
  logic [7:0]     rdata_q;

  logic [PW-1:0]  psel;
  logic [7:0]     osel, vsel, bmask, wdata, len_m1, row_base;
  logic [8:0]     thr;
  logic           re, we, load, scan_last, clr_last, wr_last, last_row;
  logic [2:0]     row;
  logic [AW-1:0]  wr_addr, sc_addr, waddr, raddr;

  function automatic logic [PW-1:0] p_inc(logic [PW-1:0] p);
    return (p == P_LAST) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    case (ch_q)
      2'd1: begin psel = pg_q; osel = head_i.off_g; vsel = head_i.green; end
      2'd2: begin psel = pb_q; osel = head_i.off_b; vsel = head_i.blue; end
      default: begin psel = c_q; osel = head_i.off_r; vsel = head_i.red; end
    endcase
  end

  assign thr = 9'(c_q) * 9'(STEP) + 9'(HALF);
  assign bmask = 8'd1 << head_i.bitpos;
  assign wdata = ({1'b0, vsel} > thr) ? (rdata_q | bmask) : (rdata_q & ~bmask);
  assign wr_addr = AW'(psel) * AW'(PLANE_BYTES) + AW'(osel);

  assign row = scan_mode_i ? rc_q : {1'b0, rc_q[1:0]};
  assign last_row = scan_mode_i ? (row == 3'd7) : (row == 3'd3);
  assign len_m1 = scan_mode_i ? 8'd23 : 8'd47;
  assign row_base = scan_mode_i ? ({1'b0, row, 4'b0} + {2'b0, row, 3'b0})
                                : ({1'b0, row[1:0], 5'b0} + {2'b0, row[1:0], 4'b0});
  assign sc_addr = AW'(plane_q) * AW'(PLANE_BYTES) + AW'(len_m1 - {2'b0, j_q} + row_base);
  assign scan_last = ({2'b0, j_q} == len_m1);
  assign clr_last = (clr_q == AW'(DEPTH - 1));
  assign wr_last = (ch_q == 2'd2) && (c_q == P_LAST);
  assign load = (state_q == S_SC_WT) && (!out_valid_o || !out_stall_i);

  assign re = (state_q == S_WR_RD) || (state_q == S_SC_RD);
  assign we = (state_q == S_CLR) || (state_q == S_WR_WB);
  assign waddr = (state_q == S_CLR) ? clr_q : wr_addr;
  assign raddr = (state_q == S_SC_RD) ? sc_addr : wr_addr;
  assign busy_o = init_q;

  always_comb begin
    pop_o = 1'b0;
    case (state_q)
      S_CLR:   pop_o = clr_last && !init_q;
      S_WR_WB: pop_o = wr_last;
      S_SC_WT: pop_o = load && scan_last;
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= (state_q == S_CLR) ? 8'd0 : wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_byte_o <= rdata_q;
      row_select_o <= row;
      plane_index_o <= 3'(plane_q);
      last_in_row_o <= scan_last;
      enable_time_o <= on_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      init_q <= 1'b1;
      clr_q <= '0;
      c_q <= '0;
      pg_q <= '0;
      pb_q <= '0;
      ch_q <= 2'd0;
      j_q <= 6'd0;
      rc_q <= 3'd0;
      plane_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            case (head_i.kind)
              K_WRITE: begin
                c_q <= '0;
                pg_q <= G0;
                pb_q <= B0;
                ch_q <= 2'd0;
                state_q <= S_WR_RD;
              end
              K_CLEAR: begin
                clr_q <= '0;
                state_q <= S_CLR;
              end
              default: begin
                j_q <= 6'd0;
                state_q <= S_SC_RD;
              end
            endcase
          end
        end
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_last) begin
            init_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        S_WR_RD: begin
          state_q <= S_WR_WB;
        end
        S_WR_WB: begin
          if (ch_q == 2'd2) begin
            ch_q <= 2'd0;
            c_q <= p_inc(c_q);
            pg_q <= p_inc(pg_q);
            pb_q <= p_inc(pb_q);
          end else begin
            ch_q <= ch_q + 2'd1;
          end
          state_q <= wr_last ? S_IDLE : S_WR_RD;
        end
        S_SC_RD: begin
          state_q <= S_SC_WT;
        end
        S_SC_WT: begin
          if (load) begin
            if (scan_last) begin
              if (last_row) begin
                rc_q <= 3'd0;
                plane_q <= p_inc(plane_q);
              end else begin
                rc_q <= row + 3'd1;
              end
              state_q <= S_IDLE;
            end else begin
              j_q <= j_q + 6'd1;
              state_q <= S_SC_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/core/led_matrix_bitplane_scan.sv =====
// Top level of the LED matrix bit-plane frame store and row scanner.
//  channel  | direction | handshake             | payload
//  in       | input     | in_valid_i/in_stall_o | operation, pos_x, pos_y, colors
//  out      | output    | out_valid_o/out_stall_i | data_byte, row_select, plane, last, time
//  cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// Each item is dispatched from the back end's idle state, then:
// a pixel write reads, then writes back, three bytes in each plane over the
// single store port;
// a scan reads and sends each byte of the row in turn, waiting under output
// stalls: 48 bytes for a four-row row, 24 for an eight-row row;
// a clear one byte a cycle over all NUM_PLANES*192 bytes; the same sweep runs
// after reset, with in_stall_o high until it ends.
// Writes out of range are taken and dropped; a two-entry queue buffers items.
module led_matrix_bitplane_scan
  import lmbs_pkg::*;
#(
  parameter int unsigned NUM_PLANES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic [5:0]           pos_x_i,
  input  logic [4:0]           pos_y_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic [15:0]          packed_color_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           data_byte_o,
  output logic [2:0]           row_select_o,
  output logic [2:0]           plane_index_o,
  output logic                 last_in_row_o,
  output logic [15:0]          enable_time_o
);
  logic        scan_mode_q;
  logic [15:0] on_time_q;
  logic        push, pop, empty, full, busy;
  entry_t      entry, head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = full || busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q <= 1'b0;
      on_time_q <= 16'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_SCAN_MODE) begin
        scan_mode_q <= cfg_data_i[0];
      end else if (cfg_index_i == REG_ON_TIME) begin
        on_time_q <= cfg_data_i;
      end
    end
  end

  lmbs_front u_front (
    .accept_i      (in_valid_i && !in_stall_o),
    .scan_mode_i   (scan_mode_q),
    .operation_i   (operation_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .packed_color_i(packed_color_i),
    .push_o        (push),
    .entry_o       (entry)
  );

  lmbs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .full_o (full)
  );

  lmbs_back #(
    .NUM_PLANES(NUM_PLANES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_mode_i  (scan_mode_q),
    .on_time_i    (on_time_q),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .row_select_o (row_select_o),
    .plane_index_o(plane_index_o),
    .last_in_row_o(last_in_row_o),
    .enable_time_o(enable_time_o)
  );
endmodule
